// ----- design/ita_pkg.sv -----
// shared constants, types and helper functions of the integer to ascii formatter
package ita_pkg;

   localparam int VALUE_W  = 64;
   localparam int COUNT_W  = 16;
   localparam int CHAR_W   = 7;
   localparam int ACTION_W = 2;
   localparam int NIB_W    = 4;
   localparam int DIGITS   = 20;
   localparam int BCD_W    = DIGITS * NIB_W;
   localparam int LEFT_W   = $clog2(DIGITS + 1);
   localparam int BIT_CNT_W = $clog2(VALUE_W);
   localparam int HEX32_DIGITS = 8;
   localparam int HEX64_DIGITS = 16;

   localparam logic [ACTION_W-1:0] ACT_DEC     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_HEX32_L = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_HEX32_U = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_HEX64_L = 2'd3;

   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_UA    = 7'h41;
   localparam logic [CHAR_W-1:0] ASCII_LA    = 7'h61;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

   // load command for the character serializer
   typedef struct packed {
      logic [BCD_W-1:0]   digits;
      logic [LEFT_W-1:0]  ndig;
      logic               neg;
      logic               upper;
      logic [COUNT_W-1:0] start;
   } emit_cmd_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] dx;
      logic [CHAR_W-1:0] res;
      dx = {{(CHAR_W-NIB_W){1'b0}}, d};
      if (d < 4'd10) begin
         res = ASCII_ZERO + dx;
      end else if (upper) begin
         res = ASCII_UA + dx - 7'd10;
      end else begin
         res = ASCII_LA + dx - 7'd10;
      end
      return res;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] res;
      res = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
      return res;
   endfunction

endpackage

// ----- design/ita_if.sv -----
// handshake channels for the number requests and the character responses
interface ita_req_if import ita_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  value;
   logic [COUNT_W-1:0]  start_count;

   modport source (output valid, output action, output value, output start_count,
                   input ready);
   modport sink   (input valid, input action, input value, input start_count,
                   output ready);
endinterface

interface ita_rsp_if import ita_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  char_code;
   logic               is_last;
   logic [COUNT_W-1:0] char_count;

   modport source (output valid, output char_code, output is_last, output char_count,
                   input ready);
   modport sink   (input valid, input char_code, input is_last, input char_count,
                   output ready);
endinterface

// ----- design/ita_dabble.sv -----
// bit-serial binary to bcd converter, shift-and-add-3, one input bit per cycle
module ita_dabble import ita_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [VALUE_W-1:0] mag,
   output logic [BCD_W-1:0]   bcd,
   output logic               done
);

   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [BCD_W-1:0]     adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*NIB_W +: NIB_W] >= 4'd5) begin
            adj[i*NIB_W +: NIB_W] = bcd_ff[i*NIB_W +: NIB_W] + 4'd3;
         end else begin
            adj[i*NIB_W +: NIB_W] = bcd_ff[i*NIB_W +: NIB_W];
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in = mag;
         bcd_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign bcd  = bcd_ff;
   assign done = done_ff;

endmodule

// ----- design/ita_emit.sv -----
// digit shifter: drops leading zeros, then sends sign and digits one per cycle while the output slot is free
module ita_emit import ita_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  emit_cmd_type  cmd,
   output logic          busy,
   ita_rsp_if.source     rsp
);

   typedef enum logic [3:0] {
      E_IDLE  = 4'b0001,
      E_SKIP  = 4'b0010,
      E_SIGN  = 4'b0100,
      E_DIGIT = 4'b1000
   } emit_state_type;

   emit_state_type     state_ff, state_in;
   logic [BCD_W-1:0]   digits_ff, digits_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic               neg_ff, neg_in;
   logic               upper_ff, upper_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_code_ff, out_code_in;
   logic               out_last_ff, out_last_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic               slot_free;
   logic [NIB_W-1:0]   top_nib;

   assign slot_free = !out_valid_ff || rsp.ready;
   assign top_nib   = digits_ff[BCD_W-1 -: NIB_W];

   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      left_in      = left_ff;
      neg_in       = neg_ff;
      upper_in     = upper_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      out_count_in = out_count_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (load) begin
               digits_in = cmd.digits;
               left_in   = cmd.ndig;
               neg_in    = cmd.neg;
               upper_in  = cmd.upper;
               count_in  = cmd.start;
               state_in  = E_SKIP;
            end
         end
         E_SKIP: begin
            if (top_nib == '0 && left_ff > LEFT_W'(1)) begin
               digits_in = {digits_ff[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
               left_in   = left_ff - 1'b1;
            end else begin
               state_in = neg_ff ? E_SIGN : E_DIGIT;
            end
         end
         E_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_code_in  = ASCII_MINUS;
               out_last_in  = 1'b0;
               out_count_in = sat_inc(count_ff);
               count_in     = sat_inc(count_ff);
               state_in     = E_DIGIT;
            end
         end
         E_DIGIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_code_in  = digit_char(top_nib, upper_ff);
               out_last_in  = (left_ff == LEFT_W'(1));
               out_count_in = sat_inc(count_ff);
               count_in     = sat_inc(count_ff);
               digits_in    = {digits_ff[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
               left_in      = left_ff - 1'b1;
               if (left_ff == LEFT_W'(1)) begin
                  state_in = E_IDLE;
               end
            end
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff    <= digits_in;
      left_ff      <= left_in;
      neg_ff       <= neg_in;
      upper_ff     <= upper_in;
      count_ff     <= count_in;
      out_code_ff  <= out_code_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= out_count_in;
      if (reset) begin
         state_ff     <= E_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign busy           = (state_ff != E_IDLE);
   assign rsp.valid      = out_valid_ff;
   assign rsp.char_code  = out_code_ff;
   assign rsp.is_last    = out_last_ff;
   assign rsp.char_count = out_count_ff;

endmodule

// ----- design/integer_to_ascii_formatter.sv -----
// decimal: the converter shifts in the magnitude after the accept and then loads
// the digit shifter, which skips leading zeros and sends a minus sign when negative and
// then the digits while rsp is ready; hex: the shifter loads at the accept
// one word in flight; the next is accepted only after the last character is registered
// and the shifter has returned to idle
// synchronous active-high reset returns to idle with no response pending
module integer_to_ascii_formatter import ita_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ita_req_if.sink   req,
   ita_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } top_state_type;

   top_state_type      state_ff, state_in;
   logic               neg_ff, neg_in;
   logic [COUNT_W-1:0] start_ff, start_in;

   logic               accept;
   logic               neg_now;
   logic [VALUE_W-1:0] mag_now;
   logic               conv_start;
   logic [BCD_W-1:0]   conv_bcd;
   logic               conv_done;
   logic               emit_load;
   logic               emit_busy;
   emit_cmd_type       emit_cmd;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   // magnitude as unsigned so the most negative value converts cleanly
   assign neg_now = (req.action == ACT_DEC) && req.value[VALUE_W-1];
   assign mag_now = neg_now ? (~req.value + 1'b1) : req.value;

   assign conv_start = accept && (req.action == ACT_DEC);

   ita_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .mag   (mag_now),
      .bcd   (conv_bcd),
      .done  (conv_done)
   );

   always_comb begin
      emit_load = 1'b0;
      emit_cmd  = '0;
      if (state_ff == ST_CONV) begin
         emit_load       = conv_done;
         emit_cmd.digits = conv_bcd;
         emit_cmd.ndig   = LEFT_W'(DIGITS);
         emit_cmd.neg    = neg_ff;
         emit_cmd.upper  = 1'b0;
         emit_cmd.start  = start_ff;
      end else begin
         emit_load      = accept && (req.action != ACT_DEC);
         emit_cmd.neg   = 1'b0;
         emit_cmd.upper = (req.action == ACT_HEX32_U);
         emit_cmd.start = req.start_count;
         if (req.action == ACT_HEX64_L) begin
            emit_cmd.digits = {req.value, {(BCD_W-VALUE_W){1'b0}}};
            emit_cmd.ndig   = LEFT_W'(HEX64_DIGITS);
         end else begin
            emit_cmd.digits = {req.value[VALUE_W/2-1:0], {(BCD_W-VALUE_W/2){1'b0}}};
            emit_cmd.ndig   = LEFT_W'(HEX32_DIGITS);
         end
      end
   end

   ita_emit u_emit (
      .clock (clock),
      .reset (reset),
      .load  (emit_load),
      .cmd   (emit_cmd),
      .busy  (emit_busy),
      .rsp   (rsp)
   );

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      start_in = start_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = neg_now;
               start_in = req.start_count;
               state_in = (req.action == ACT_DEC) ? ST_CONV : ST_EMIT;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // busy rises the cycle after the load, so this waits for the real end
            if (!emit_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff   <= neg_in;
      start_ff <= start_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- tb/sv/integer_to_ascii_formatter_tb.sv -----
// self-checking testbench for the integer to ascii formatter
module integer_to_ascii_formatter_tb;
   import ita_pkg::*;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VALUE_W-1:0]  value;
      logic [COUNT_W-1:0]  start_count;
   } number_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  char_code;
      logic               is_last;
      logic [COUNT_W-1:0] char_count;
   } char_type;

   localparam logic [16*8-1:0] LOWER_TAB = "0123456789abcdef";
   localparam logic [16*8-1:0] UPPER_TAB = "0123456789ABCDEF";
   localparam int MAX_CHARS     = 20;
   localparam int RANDOM_ITEMS  = 250;
   localparam int TAIL_ITEMS    = 30;
   localparam int LONG_STALL    = 600;
   localparam int DRAIN_CYCLES  = 150;

   logic clock;
   logic reset;

   ita_req_if req_ch ();
   ita_rsp_if rsp_ch ();

   integer_to_ascii_formatter dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   number_type pending_numbers[$];
   char_type   expected_chars[$];

   int error_count    = 0;
   int chars_checked  = 0;
   int numbers_taken  = 0;
   int mode_taken[4]  = '{0, 0, 0, 0};
   int src_gap        = 0;
   int src_calm       = 0;
   int sink_hold      = 0;
   int sink_calm      = 0;
   bit long_stall_done = 0;

   function automatic logic [CHAR_W-1:0] table_char(input int d, input bit upper);
      logic [7:0] b;
      b = upper ? UPPER_TAB[(15 - d) * 8 +: 8] : LOWER_TAB[(15 - d) * 8 +: 8];
      return b[CHAR_W-1:0];
   endfunction

   // expands one number into the characters it should produce
   function automatic void predict_chars(input number_type n);
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0]  rev [MAX_CHARS];
      logic [CHAR_W-1:0]  seq [MAX_CHARS];
      logic [COUNT_W:0]   cnt;
      bit                 neg;
      bit                 upper;
      int                 nrev;
      int                 nseq;
      char_type           c;
      nrev = 0;
      nseq = 0;
      if (n.action == ACT_DEC) begin
         neg = n.value[VALUE_W-1];
         // unsigned magnitude keeps the most negative value intact
         mag = neg ? (~n.value + 1'b1) : n.value;
         do begin
            rev[nrev] = table_char(int'(mag % 10), 1'b0);
            nrev++;
            mag = mag / 10;
         end while (mag != 0 && nrev < MAX_CHARS);
         if (neg) begin
            seq[nseq] = ASCII_MINUS;
            nseq++;
         end
      end else begin
         upper = (n.action == ACT_HEX32_U);
         mag = (n.action == ACT_HEX64_L) ? n.value : {32'b0, n.value[31:0]};
         do begin
            rev[nrev] = table_char(int'(mag[3:0]), upper);
            nrev++;
            mag = mag >> 4;
         end while (mag != 0 && nrev < MAX_CHARS);
      end
      while (nrev > 0 && nseq < MAX_CHARS) begin
         nrev--;
         seq[nseq] = rev[nrev];
         nseq++;
      end
      for (int k = 0; k < nseq; k++) begin
         cnt = {1'b0, n.start_count} + 17'(k + 1);
         c.char_code  = seq[k];
         c.is_last    = (k == nseq - 1);
         c.char_count = (cnt > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt[COUNT_W-1:0];
         expected_chars.push_back(c);
      end
   endfunction

   task automatic add_number(input logic [ACTION_W-1:0] a, input logic [VALUE_W-1:0] v,
                             input logic [COUNT_W-1:0] s);
      number_type n;
      n.action      = a;
      n.value       = v;
      n.start_count = s;
      pending_numbers.push_back(n);
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] small_v;
      v = {$urandom, $urandom};
      small_v = 64'($urandom_range(0, 1000));
      case ($urandom_range(0, 5))
         0: v = v;
         1: v = small_v;
         2: v = v >> $urandom_range(0, 63);
         3: v = ~small_v + 1'b1;
         4: begin
            case ($urandom_range(0, 2))
               0: v = 64'h8000_0000_0000_0000 + small_v;
               1: v = 64'h7fff_ffff_ffff_ffff - small_v;
               default: v = 64'hffff_ffff_ffff_ffff - small_v;
            endcase
         end
         default: v = {32'($urandom), 32'($urandom) >> $urandom_range(0, 31)};
      endcase
      return v;
   endfunction

   function automatic logic [COUNT_W-1:0] random_start();
      logic [COUNT_W-1:0] s;
      case ($urandom_range(0, 7))
         0: s = '0;
         1, 2: s = COUNT_W'($urandom_range(65515, 65535));
         default: s = COUNT_W'($urandom);
      endcase
      return s;
   endfunction

   // driver: offers pending numbers, records each accepted word
   always @(posedge clock) begin
      number_type n;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            n.action      = req_ch.action;
            n.value       = req_ch.value;
            n.start_count = req_ch.start_count;
            predict_chars(n);
            numbers_taken++;
            mode_taken[n.action]++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_numbers.size() > 0) begin
               n = pending_numbers.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.action      <= n.action;
               req_ch.value       <= n.value;
               req_ch.start_count <= n.start_count;
               if (src_calm > 0) begin
                  src_calm--;
               end else if (pending_numbers.size() > TAIL_ITEMS &&
                            $urandom_range(0, 3) == 0) begin
                  if ($urandom_range(0, 9) == 0) src_calm = $urandom_range(10, 40);
                  else src_gap = $urandom_range(1, 14);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random hold-offs plus one long stall to back up the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (sink_hold > 0) begin
         sink_hold--;
         rsp_ch.ready <= (sink_hold == 0);
      end else if (!long_stall_done && chars_checked >= 60) begin
         long_stall_done = 1'b1;
         sink_hold = LONG_STALL;
         rsp_ch.ready <= 1'b0;
      end else if (sink_calm > 0) begin
         sink_calm--;
         rsp_ch.ready <= 1'b1;
      end else if (pending_numbers.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
         if ($urandom_range(0, 9) == 0) begin
            sink_calm = $urandom_range(20, 80);
            rsp_ch.ready <= 1'b1;
         end else begin
            sink_hold = $urandom_range(1, 14);
            rsp_ch.ready <= 1'b0;
         end
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor: every accepted word is checked against the oldest expected character
   always @(posedge clock) begin
      char_type exp_c;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character code=%h last=%b count=%0d", $time,
                     rsp_ch.char_code, rsp_ch.is_last, rsp_ch.char_count);
            error_count++;
         end else begin
            exp_c = expected_chars.pop_front();
            if (rsp_ch.char_code !== exp_c.char_code) begin
               $display("%0t: char_code expected %h actual %h", $time, exp_c.char_code,
                        rsp_ch.char_code);
               error_count++;
            end
            if (rsp_ch.is_last !== exp_c.is_last) begin
               $display("%0t: is_last expected %b actual %b", $time, exp_c.is_last,
                        rsp_ch.is_last);
               error_count++;
            end
            if (rsp_ch.char_count !== exp_c.char_count) begin
               $display("%0t: char_count expected %0d actual %0d", $time, exp_c.char_count,
                        rsp_ch.char_count);
               error_count++;
            end
         end
         chars_checked++;
      end
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_DEC;
      req_ch.value       = '0;
      req_ch.start_count = '0;
      rsp_ch.ready       = 1'b0;
      reset              = 1'b1;

      // zeros and all-ones in every mode
      add_number(ACT_DEC,     64'h0, 16'd0);
      add_number(ACT_HEX32_L, 64'h0, 16'd0);
      add_number(ACT_HEX32_U, 64'h0, 16'd65535);
      add_number(ACT_HEX64_L, 64'h0, 16'd7);
      add_number(ACT_DEC,     64'hffff_ffff_ffff_ffff, 16'd0);
      add_number(ACT_HEX32_L, 64'hffff_ffff_ffff_ffff, 16'd65530);
      add_number(ACT_HEX32_U, 64'hffff_ffff_ffff_ffff, 16'd1);
      add_number(ACT_HEX64_L, 64'hffff_ffff_ffff_ffff, 16'd65534);
      // decimal edges, most negative value included
      add_number(ACT_DEC, 64'h8000_0000_0000_0000, 16'd0);
      add_number(ACT_DEC, 64'h8000_0000_0000_0000, 16'd65530);
      add_number(ACT_DEC, 64'h7fff_ffff_ffff_ffff, 16'd100);
      add_number(ACT_DEC, 64'd1, 16'd65535);
      add_number(ACT_DEC, 64'd9, 16'd3);
      add_number(ACT_DEC, 64'd10, 16'd3);
      add_number(ACT_DEC, 64'd1_000_000_000_000_000_000, 16'd0);
      add_number(ACT_DEC, ~64'd1_234_567_890 + 1'b1, 16'd12345);
      // hex letters, and upper bits ignored in 32-bit modes
      add_number(ACT_HEX32_L, 64'h1234_5678_dead_beef, 16'd0);
      add_number(ACT_HEX32_U, 64'h1234_5678_dead_beef, 16'd0);
      add_number(ACT_HEX32_L, 64'h0000_0001_0000_0000, 16'd42);
      add_number(ACT_HEX64_L, 64'h0000_0001_0000_0000, 16'd42);
      add_number(ACT_HEX64_L, 64'hfedc_ba98_7654_3210, 16'd65520);
      add_number(ACT_HEX32_U, 64'h0000_0000_abcd_ef01, 16'd65532);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_number(ACTION_W'($urandom_range(0, 3)), random_value(), random_start());
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() > 0 || req_ch.valid) @(posedge clock);
      while (expected_chars.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d numbers (decimal %0d, hex32 lower %0d, hex32 upper %0d, hex64 %0d)",
               numbers_taken, mode_taken[ACT_DEC], mode_taken[ACT_HEX32_L],
               mode_taken[ACT_HEX32_U], mode_taken[ACT_HEX64_L]);
      $display("checked %0d characters, %0d mismatches", chars_checked, error_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
